// ===== hdl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared constants and character-class helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Number of result bytes one input byte can produce.
  localparam int MAX_RESULTS = 3;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Valid only when is_hex(c); letters of either case map to 10..15.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  // Values that stay escaped as literal text.
  function automatic logic is_safe(input logic [7:0] v);
    return (v inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A], [8'h27:8'h2F],
                      8'h21, 8'h24, 8'h26, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F});
  endfunction

endpackage

// ===== hdl/upd_in_if.sv =====
// ----------------------------------------------------------------------------
// upd_in_if
// Encoded byte channel: one URL byte per item plus end-of-string flag.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/upd_out_if.sv =====
// ----------------------------------------------------------------------------
// upd_out_if
// Decoded byte channel: one decoded byte per item plus end-of-string flag.
// ----------------------------------------------------------------------------
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/url_percent_decoder.sv =====
// Timing: results of an item reach the output in the cycle after it is accepted
//   when the output queue is empty; later results follow one byte per cycle while dec.ready holds.
// Throughput: one input item per cycle while enc.ready is high; the output drains
//   one byte per cycle while dec.ready is high, set by the queue's single read port.
// Reset (rst, synchronous): clears escape state and queue pointers; the queue
//   storage itself is not cleared.
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streams URL bytes, decodes '+' and non-safe %XX escapes, queues results.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
  parameter int FIFO_AW = 3
) (
  input  logic             clk,
  input  logic             rst,
  upd_in_if.sink           enc,
  upd_out_if.source        dec
);

  localparam int DEPTH = 1 << FIFO_AW;
  localparam logic [FIFO_AW:0] READY_MAX = (FIFO_AW + 1)'(DEPTH - upd_pkg::MAX_RESULTS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } entry_t;

  phase_t            phase;
  logic [7:0]        held_digit;

  entry_t            fifo [DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  phase_t            phase_next;
  logic [7:0]        held_next;
  logic [7:0]        res [upd_pkg::MAX_RESULTS];
  logic [1:0]        n_res;
  logic              do_plain;

  logic [7:0]        c;
  logic [7:0]        dec_val;
  logic              accept;
  logic              pop;

  assign c       = enc.in_byte;
  assign dec_val = {upd_pkg::hex_nibble(held_digit), upd_pkg::hex_nibble(c)};
  assign accept  = enc.valid && enc.ready;
  assign pop     = dec.valid && dec.ready;

  assign enc.ready    = (count <= READY_MAX);
  assign dec.valid    = (count != '0);
  assign dec.out_byte = fifo[rd_ptr].data;
  assign dec.out_last = fifo[rd_ptr].last;

  always_comb begin
    phase_next = phase;
    held_next  = held_digit;
    n_res      = '0;
    do_plain   = 1'b0;
    for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    case (phase)
      PH_PCT: begin
        if (upd_pkg::is_hex(c)) begin
          held_next  = c;
          phase_next = PH_DIGIT;
        end else begin
          phase_next = PH_IDLE;
          res[n_res] = upd_pkg::CHAR_PCT;
          n_res      = n_res + 2'd1;
          do_plain   = 1'b1;
        end
      end
      PH_DIGIT: begin
        phase_next = PH_IDLE;
        if (upd_pkg::is_hex(c) && upd_pkg::is_hex(held_digit)) begin
          if (upd_pkg::is_safe(dec_val)) begin
            res[0] = upd_pkg::CHAR_PCT;
            res[1] = held_digit;
            res[2] = c;
            n_res  = 2'd3;
          end else begin
            res[0] = dec_val;
            n_res  = 2'd1;
          end
        end else begin
          res[0]   = upd_pkg::CHAR_PCT;
          res[1]   = held_digit;
          n_res    = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        // the idle phase and the unused phase code take plain-byte handling
        phase_next = PH_IDLE;
        do_plain   = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (c == upd_pkg::CHAR_PLUS) begin
        res[n_res] = upd_pkg::CHAR_SPACE;
        n_res      = n_res + 2'd1;
      end else if (c == upd_pkg::CHAR_PCT) begin
        phase_next = PH_PCT;
      end else begin
        res[n_res] = c;
        n_res      = n_res + 2'd1;
      end
    end

    // end of string: pending escape text goes out as literals
    if (enc.in_last) begin
      if (phase_next == PH_PCT) begin
        res[n_res] = upd_pkg::CHAR_PCT;
        n_res      = n_res + 2'd1;
      end else if (phase_next == PH_DIGIT) begin
        res[n_res] = upd_pkg::CHAR_PCT;
        n_res      = n_res + 2'd1;
        res[n_res] = held_next;
        n_res      = n_res + 2'd1;
      end
      phase_next = PH_IDLE;
      held_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        held_digit <= held_next;
        wr_ptr     <= wr_ptr + FIFO_AW'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (accept ? (FIFO_AW + 1)'(n_res) : '0)
                     - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
      if (accept && (2'(i) < n_res)) begin
        fifo[wr_ptr + FIFO_AW'(i)] <= '{last: enc.in_last && (2'(i) == n_res - 2'd1),
                                       data: res[i]};
      end
    end
  end

endmodule

// ===== hdl/upd_checker.sv =====
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       enc_valid,
  input logic       enc_ready,
  input logic       dec_valid,
  input logic       dec_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled output item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(out_byte) && $stable(out_last))
    else $error("output item changed while stalled");

  // an empty output queue always has room for a new item
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !dec_valid |-> enc_ready)
    else $error("input stalled with empty output queue");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> !dec_valid && enc_ready)
    else $error("block not empty and ready after reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .enc_valid (enc.valid),
  .enc_ready (enc.ready),
  .dec_valid (dec.valid),
  .dec_ready (dec.ready),
  .out_byte  (dec.out_byte),
  .out_last  (dec.out_last)
);
